FILE: hw/rtl/scol_pkg.sv
// Shared shape codes and pipeline control types for the shape pair collision test.
package scol_pkg;

    localparam logic [1:0] SHAPE_DISC     = 2'd0;
    localparam logic [1:0] SHAPE_TOP_LEFT = 2'd1;
    localparam logic [1:0] SHAPE_BOT_LEFT = 2'd2;
    localparam logic [1:0] SHAPE_CENTRE   = 2'd3;

    localparam int SHAPE_BITS = 2;

    // Control carried out of the extent stage
    typedef struct packed {
        logic both_en;
        logic a_circle;
        logic b_circle;
    } pair_ctl_t;

    // Control carried out of the clamp stage to the final compare
    typedef struct packed {
        logic both_en;
        logic box_pair;
        logic overlap;
    } res_ctl_t;

endpackage

FILE: hw/rtl/scol_extent.sv
// Stage one: inclusive box extents of one object, plus its registered centre and radius.
module scol_extent
    import scol_pkg::*;
#(
    parameter int CW = 12,
    parameter int SW = 8,
    parameter int EW = 14
)
(
    input  logic                  clk,
    input  logic                  ld,
    input  logic [SHAPE_BITS-1:0] shape,
    input  logic signed [CW-1:0]  x,
    input  logic signed [CW-1:0]  y,
    input  logic [SW-1:0]         size,
    input  logic [SW-1:0]         height,
    output logic signed [EW-1:0]  left_reg,
    output logic signed [EW-1:0]  right_reg,
    output logic signed [EW-1:0]  top_reg,
    output logic signed [EW-1:0]  bottom_reg,
    output logic signed [CW-1:0]  cx_reg,
    output logic signed [CW-1:0]  cy_reg,
    output logic [SW-1:0]         rad_reg
);

    logic signed [EW-1:0] xe;
    logic signed [EW-1:0] ye;
    logic signed [EW-1:0] we;
    logic signed [EW-1:0] he;
    logic signed [EW-1:0] left_next;
    logic signed [EW-1:0] right_next;
    logic signed [EW-1:0] top_next;
    logic signed [EW-1:0] bottom_next;

    always_comb
    begin
        xe = EW'(x);
        ye = EW'(y);
        we = $signed({{(EW-SW){1'b0}}, size});
        he = $signed({{(EW-SW){1'b0}}, height});
        case (shape)
            SHAPE_DISC, SHAPE_TOP_LEFT:
            begin
                left_next   = xe;
                right_next  = xe + we;
                top_next    = ye;
                bottom_next = ye + he;
            end
            SHAPE_BOT_LEFT:
            begin
                left_next   = xe;
                right_next  = xe + we;
                top_next    = ye - he;
                bottom_next = ye;
            end
            default:
            begin
                // truncating half sizes: an odd size loses one pixel
                left_next   = xe - (we >>> 1);
                right_next  = xe + (we >>> 1);
                top_next    = ye - (he >>> 1);
                bottom_next = ye + (he >>> 1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            cx_reg     <= x;
            cy_reg     <= y;
            rad_reg    <= size;
        end
    end

endmodule

FILE: hw/rtl/scol_clamp.sv
// Stage two: pick the pair case, clamp the circle centre into the box, test box overlap.
module scol_clamp
    import scol_pkg::*;
#(
    parameter int CW = 12,
    parameter int SW = 8,
    parameter int EW = 14,
    parameter int DW = 15
)
(
    input  logic                 clk,
    input  logic                 ld,
    input  pair_ctl_t            ctl,
    input  logic signed [EW-1:0] a_left,
    input  logic signed [EW-1:0] a_right,
    input  logic signed [EW-1:0] a_top,
    input  logic signed [EW-1:0] a_bottom,
    input  logic signed [CW-1:0] a_cx,
    input  logic signed [CW-1:0] a_cy,
    input  logic [SW-1:0]        a_rad,
    input  logic signed [EW-1:0] b_left,
    input  logic signed [EW-1:0] b_right,
    input  logic signed [EW-1:0] b_top,
    input  logic signed [EW-1:0] b_bottom,
    input  logic signed [CW-1:0] b_cx,
    input  logic signed [CW-1:0] b_cy,
    input  logic [SW-1:0]        b_rad,
    output logic signed [DW-1:0] dx_reg,
    output logic signed [DW-1:0] dy_reg,
    output logic [SW:0]          r_reg,
    output res_ctl_t             rctl_reg
);

    logic signed [DW-1:0] cxe;
    logic signed [DW-1:0] cye;
    logic signed [DW-1:0] le;
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] te;
    logic signed [DW-1:0] be;
    logic [SW-1:0]        crad;
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dy_next;
    logic [SW:0]          r_next;
    res_ctl_t             rctl_next;

    always_comb
    begin
        // circle against the other object's box
        if (ctl.a_circle)
        begin
            cxe  = DW'(a_cx);
            cye  = DW'(a_cy);
            crad = a_rad;
            le   = DW'(b_left);
            re   = DW'(b_right);
            te   = DW'(b_top);
            be   = DW'(b_bottom);
        end
        else
        begin
            cxe  = DW'(b_cx);
            cye  = DW'(b_cy);
            crad = b_rad;
            le   = DW'(a_left);
            re   = DW'(a_right);
            te   = DW'(a_top);
            be   = DW'(a_bottom);
        end

        if (ctl.a_circle && ctl.b_circle)
        begin
            dx_next = DW'(a_cx) - DW'(b_cx);
            dy_next = DW'(a_cy) - DW'(b_cy);
            r_next  = {1'b0, a_rad} + {1'b0, b_rad};
        end
        else
        begin
            if (cxe < le)
                dx_next = cxe - le;
            else if (cxe > re)
                dx_next = cxe - re;
            else
                dx_next = '0;
            if (cye < te)
                dy_next = cye - te;
            else if (cye > be)
                dy_next = cye - be;
            else
                dy_next = '0;
            r_next = {1'b0, crad};
        end

        rctl_next.both_en  = ctl.both_en;
        rctl_next.box_pair = !ctl.a_circle && !ctl.b_circle;
        rctl_next.overlap  = !(a_right < b_left || a_left > b_right ||
                               a_bottom < b_top || a_top > b_bottom);
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            r_reg    <= r_next;
            rctl_reg <= rctl_next;
        end
    end

endmodule

FILE: hw/rtl/scol_square.sv
// Stage three: squared distance terms and squared radius.
module scol_square
    import scol_pkg::*;
#(
    parameter int DW = 15,
    parameter int RW = 9
)
(
    input  logic                 clk,
    input  logic                 ld,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    input  logic [RW-1:0]        r,
    input  res_ctl_t             rctl,
    output logic [2*DW-1:0]      dx2_reg,
    output logic [2*DW-1:0]      dy2_reg,
    output logic [2*RW-1:0]      r2_reg,
    output res_ctl_t             rctl_reg
);

    logic signed [2*DW-1:0] dx2_next;
    logic signed [2*DW-1:0] dy2_next;
    logic [2*RW-1:0]        r2_next;

    always_comb
    begin
        dx2_next = (2*DW)'(dx) * (2*DW)'(dx);
        dy2_next = (2*DW)'(dy) * (2*DW)'(dy);
        r2_next  = (2*RW)'(r) * (2*RW)'(r);
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            dx2_reg  <= $unsigned(dx2_next);
            dy2_reg  <= $unsigned(dy2_next);
            r2_reg   <= r2_next;
            rctl_reg <= rctl;
        end
    end

endmodule

FILE: hw/rtl/shape_pair_collision_test_unit.sv
// Top level: stream ports, pipeline valid control and final distance compare.
// Path: an input word passes the extent, clamp, square and compare-and-output
// registers, the first loaded at the accept edge, before output tvalid rises.
// Throughput: one word per cycle; a stage stalls in place only when the next is full and held.
// Reset: rst_n clears all stage valid bits asynchronously; datapath registers are not reset.
module shape_pair_collision_test_unit
    import scol_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int SIZE_BITS  = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_x, a_y, a_size, a_height, a_enabled, b_x, b_y, b_size, b_height,
    // b_enabled, zero fill
    input  logic [((2*(2*COORD_BITS+2*SIZE_BITS+1))+7)/8*8-1:0] s_axis_tdata,
    // a_shape, b_shape
    input  logic [2*SHAPE_BITS-1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // hit, zero fill
    output logic [7:0] m_axis_tdata
);

    localparam int CW     = COORD_BITS;
    localparam int SW     = SIZE_BITS;
    localparam int EW     = ((CW > SW) ? CW : SW) + 2;
    localparam int DW     = EW + 1;
    localparam int RW     = SW + 1;
    localparam int SUMW   = 2*DW + 1;
    localparam int OBJ_W  = 2*CW + 2*SW + 1;
    localparam int OFS_X  = 0;
    localparam int OFS_Y  = CW;
    localparam int OFS_SZ = 2*CW;
    localparam int OFS_HT = 2*CW + SW;
    localparam int OFS_EN = 2*CW + 2*SW;

    logic ld1;
    logic ld2;
    logic ld3;
    logic ldo;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic vo_reg;
    logic v1_next;
    logic v2_next;
    logic v3_next;
    logic vo_next;

    logic [SHAPE_BITS-1:0] a_shape;
    logic [SHAPE_BITS-1:0] b_shape;
    logic a_enabled;
    logic b_enabled;

    pair_ctl_t ctl1_reg;
    pair_ctl_t ctl1_next;

    logic signed [EW-1:0] a_left;
    logic signed [EW-1:0] a_right;
    logic signed [EW-1:0] a_top;
    logic signed [EW-1:0] a_bottom;
    logic signed [CW-1:0] a_cx;
    logic signed [CW-1:0] a_cy;
    logic [SW-1:0]        a_rad;
    logic signed [EW-1:0] b_left;
    logic signed [EW-1:0] b_right;
    logic signed [EW-1:0] b_top;
    logic signed [EW-1:0] b_bottom;
    logic signed [CW-1:0] b_cx;
    logic signed [CW-1:0] b_cy;
    logic [SW-1:0]        b_rad;

    logic signed [DW-1:0] dx2s;
    logic signed [DW-1:0] dy2s;
    logic [RW-1:0]        r2s;
    res_ctl_t             rctl2;

    logic [2*DW-1:0] dx_sq;
    logic [2*DW-1:0] dy_sq;
    logic [2*RW-1:0] r_sq;
    res_ctl_t        rctl3;

    logic [SUMW-1:0] dist_sum;
    logic            hit_next;
    logic            hit_reg;

    // Handshake: each stage loads when empty or when its successor moves
    always_comb
    begin
        ldo = !vo_reg || m_axis_tready;
        ld3 = !v3_reg || ldo;
        ld2 = !v2_reg || ld3;
        ld1 = !v1_reg || ld2;
        v1_next = ld1 ? s_axis_tvalid : v1_reg;
        v2_next = ld2 ? v1_reg : v2_reg;
        v3_next = ld3 ? v2_reg : v3_reg;
        vo_next = ldo ? v3_reg : vo_reg;
    end

    assign s_axis_tready = ld1;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {7'b0, hit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    assign a_shape   = s_axis_tuser[0 +: SHAPE_BITS];
    assign b_shape   = s_axis_tuser[SHAPE_BITS +: SHAPE_BITS];
    assign a_enabled = s_axis_tdata[OFS_EN];
    assign b_enabled = s_axis_tdata[OBJ_W + OFS_EN];

    always_comb
    begin
        ctl1_next.both_en  = a_enabled && b_enabled;
        ctl1_next.a_circle = (a_shape == SHAPE_DISC);
        ctl1_next.b_circle = (b_shape == SHAPE_DISC);
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
            ctl1_reg <= ctl1_next;
    end

    scol_extent #(.CW(CW), .SW(SW), .EW(EW)) u_ext_a (
        .clk        (clk),
        .ld         (ld1),
        .shape      (a_shape),
        .x          ($signed(s_axis_tdata[OFS_X +: CW])),
        .y          ($signed(s_axis_tdata[OFS_Y +: CW])),
        .size       (s_axis_tdata[OFS_SZ +: SW]),
        .height     (s_axis_tdata[OFS_HT +: SW]),
        .left_reg   (a_left),
        .right_reg  (a_right),
        .top_reg    (a_top),
        .bottom_reg (a_bottom),
        .cx_reg     (a_cx),
        .cy_reg     (a_cy),
        .rad_reg    (a_rad)
    );

    scol_extent #(.CW(CW), .SW(SW), .EW(EW)) u_ext_b (
        .clk        (clk),
        .ld         (ld1),
        .shape      (b_shape),
        .x          ($signed(s_axis_tdata[OBJ_W + OFS_X +: CW])),
        .y          ($signed(s_axis_tdata[OBJ_W + OFS_Y +: CW])),
        .size       (s_axis_tdata[OBJ_W + OFS_SZ +: SW]),
        .height     (s_axis_tdata[OBJ_W + OFS_HT +: SW]),
        .left_reg   (b_left),
        .right_reg  (b_right),
        .top_reg    (b_top),
        .bottom_reg (b_bottom),
        .cx_reg     (b_cx),
        .cy_reg     (b_cy),
        .rad_reg    (b_rad)
    );

    scol_clamp #(.CW(CW), .SW(SW), .EW(EW), .DW(DW)) u_clamp (
        .clk      (clk),
        .ld       (ld2),
        .ctl      (ctl1_reg),
        .a_left   (a_left),
        .a_right  (a_right),
        .a_top    (a_top),
        .a_bottom (a_bottom),
        .a_cx     (a_cx),
        .a_cy     (a_cy),
        .a_rad    (a_rad),
        .b_left   (b_left),
        .b_right  (b_right),
        .b_top    (b_top),
        .b_bottom (b_bottom),
        .b_cx     (b_cx),
        .b_cy     (b_cy),
        .b_rad    (b_rad),
        .dx_reg   (dx2s),
        .dy_reg   (dy2s),
        .r_reg    (r2s),
        .rctl_reg (rctl2)
    );

    scol_square #(.DW(DW), .RW(RW)) u_square (
        .clk      (clk),
        .ld       (ld3),
        .dx       (dx2s),
        .dy       (dy2s),
        .r        (r2s),
        .rctl     (rctl2),
        .dx2_reg  (dx_sq),
        .dy2_reg  (dy_sq),
        .r2_reg   (r_sq),
        .rctl_reg (rctl3)
    );

    // Final compare: box pairs use the overlap bit, others the squared distance, each gated by both_en
    always_comb
    begin
        dist_sum = SUMW'(dx_sq) + SUMW'(dy_sq);
        if (rctl3.box_pair)
            hit_next = rctl3.both_en && rctl3.overlap;
        else
            hit_next = rctl3.both_en && (dist_sum <= SUMW'(r_sq));
    end

    always_ff @(posedge clk)
    begin
        if (ldo)
            hit_reg <= hit_next;
    end

    // Input stalls only when the output word is held by the consumer
    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output free");

    // An accepted word occupies the first stage on the next cycle
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted word lost at stage one");

    // A full last stage moving forward presents a word at the output
    a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ldo) |=> m_axis_tvalid)
        else $error("word lost between stage three and output");

endmodule

FILE: tb/sv/tb_shape_pair_collision_test_unit.sv
// Self-checking testbench for the shape pair collision test unit.
module tb_shape_pair_collision_test_unit
    import scol_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = 8;
    localparam int TDATA_W    = ((2*(2*COORD_BITS+2*SIZE_BITS+1))+7)/8*8;
    localparam int COORD_MIN  = -(1 << (COORD_BITS-1));
    localparam int COORD_MAX  = (1 << (COORD_BITS-1)) - 1;
    localparam int RANDOM_PAIRS = 725;
    localparam int HOLD_AT_WORD = 100;
    localparam int HOLD_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [SHAPE_BITS-1:0]        shape;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]         size;
        logic [SIZE_BITS-1:0]         height;
        logic                         en;
    } shape_obj_t;

    typedef struct {
        shape_obj_t a;
        shape_obj_t b;
    } shape_pair_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [TDATA_W-1:0]      s_axis_tdata = '0;
    logic [2*SHAPE_BITS-1:0] s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [7:0]              m_axis_tdata;

    shape_pair_t pending_pairs[$];
    bit          hit_expect_q[$];
    shape_pair_t offered_pair;
    int          total_pairs = 0;
    int          pairs_accepted = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          send_idle_pct;
    int          recv_idle_pct;

    shape_pair_collision_test_unit #(
        .COORD_BITS (COORD_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Inclusive extents of a rectangle; centre anchor halves by truncation
    function automatic void rect_extent(input shape_obj_t o, output longint lo_x,
                                        output longint lo_y, output longint hi_x,
                                        output longint hi_y);
        longint x;
        longint y;
        longint w;
        longint h;
        x = o.x;
        y = o.y;
        w = o.size;
        h = o.height;
        case (o.shape)
            SHAPE_TOP_LEFT:
            begin
                lo_x = x;
                hi_x = x + w;
                lo_y = y;
                hi_y = y + h;
            end
            SHAPE_BOT_LEFT:
            begin
                lo_x = x;
                hi_x = x + w;
                lo_y = y - h;
                hi_y = y;
            end
            default:
            begin
                lo_x = x - w / 2;
                hi_x = x + w / 2;
                lo_y = y - h / 2;
                hi_y = y + h / 2;
            end
        endcase
    endfunction

    function automatic bit circle_meets_rect(shape_obj_t circ, shape_obj_t rect);
        longint lo_x;
        longint lo_y;
        longint hi_x;
        longint hi_y;
        longint cx;
        longint cy;
        longint px;
        longint py;
        longint rad;
        rect_extent(rect, lo_x, lo_y, hi_x, hi_y);
        cx = circ.x;
        cy = circ.y;
        rad = circ.size;
        px = (cx < lo_x) ? lo_x : (cx > hi_x) ? hi_x : cx;
        py = (cy < lo_y) ? lo_y : (cy > hi_y) ? hi_y : cy;
        return (cx - px) * (cx - px) + (cy - py) * (cy - py) <= rad * rad;
    endfunction

    function automatic bit predict_hit(shape_pair_t p);
        longint dx;
        longint dy;
        longint rsum;
        longint a_lx, a_ly, a_hx, a_hy;
        longint b_lx, b_ly, b_hx, b_hy;
        if (!(p.a.en && p.b.en))
            return 1'b0;
        if (p.a.shape == SHAPE_DISC && p.b.shape == SHAPE_DISC)
        begin
            dx = longint'(p.a.x) - longint'(p.b.x);
            dy = longint'(p.a.y) - longint'(p.b.y);
            rsum = longint'(p.a.size) + longint'(p.b.size);
            return dx * dx + dy * dy <= rsum * rsum;
        end
        if (p.a.shape == SHAPE_DISC)
            return circle_meets_rect(p.a, p.b);
        if (p.b.shape == SHAPE_DISC)
            return circle_meets_rect(p.b, p.a);
        rect_extent(p.a, a_lx, a_ly, a_hx, a_hy);
        rect_extent(p.b, b_lx, b_ly, b_hx, b_hy);
        return !(a_hx < b_lx || a_lx > b_hx || a_hy < b_ly || a_ly > b_hy);
    endfunction

    function automatic shape_obj_t make_obj(logic [SHAPE_BITS-1:0] shape, int x, int y,
                                            int size, int height, bit en);
        shape_obj_t o;
        o.shape = shape;
        o.x = COORD_BITS'(x);
        o.y = COORD_BITS'(y);
        o.size = SIZE_BITS'(size);
        o.height = SIZE_BITS'(height);
        o.en = en;
        return o;
    endfunction

    function automatic shape_obj_t random_obj();
        shape_obj_t o;
        o.shape = SHAPE_BITS'($urandom);
        o.x = COORD_BITS'($urandom);
        o.y = COORD_BITS'($urandom);
        o.size = ($urandom_range(3) == 0) ? SIZE_BITS'($urandom_range(15))
                                          : SIZE_BITS'($urandom);
        o.height = ($urandom_range(3) == 0) ? SIZE_BITS'($urandom_range(15))
                                            : SIZE_BITS'($urandom);
        o.en = ($urandom_range(9) != 0);
        return o;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Most pairs put B within reach of A so that hits and near misses dominate
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int span;
        p.a = random_obj();
        p.b = random_obj();
        if ($urandom_range(99) < 75)
        begin
            span = 2 * (int'(p.a.size) + int'(p.b.size)) + 8;
            p.b.x = COORD_BITS'(clamp_coord(int'(p.a.x) + int'($urandom_range(span))
                                            - span / 2));
            p.b.y = COORD_BITS'(clamp_coord(int'(p.a.y) + int'($urandom_range(span))
                                            - span / 2));
        end
        return p;
    endfunction

    assign send_idle_pct = (pairs_accepted < total_pairs / 3) ? 38 :
                           (pairs_accepted < 2 * total_pairs / 3) ? 72 : 0;
    assign recv_idle_pct = (pairs_accepted < total_pairs / 3) ? 72 :
                           (pairs_accepted < 2 * total_pairs / 3) ? 38 : 0;

    // Driver: offer the next pending pair once the current word is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                hit_expect_q.push_back(predict_hit(offered_pair));
                pairs_accepted <= pairs_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_pair = pending_pairs.pop_front();
                    s_axis_tdata <= {{(TDATA_W-82){1'b0}},
                                     offered_pair.b.en, offered_pair.b.height,
                                     offered_pair.b.size, offered_pair.b.y,
                                     offered_pair.b.x,
                                     offered_pair.a.en, offered_pair.a.height,
                                     offered_pair.a.size, offered_pair.a.y,
                                     offered_pair.a.x};
                    s_axis_tuser <= {offered_pair.b.shape, offered_pair.a.shape};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && pairs_accepted >= HOLD_AT_WORD)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result word with the oldest predicted hit
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (hit_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %02h",
                         $time, m_axis_tdata);
                error_count = error_count + 1;
            end
            else
            begin
                want = hit_expect_q.pop_front();
                if (m_axis_tdata !== {7'b0, want})
                begin
                    $display("%0t: hit mismatch, expected %02h, actual %02h",
                             $time, {7'b0, want}, m_axis_tdata);
                    error_count = error_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int sa;
        int sb;
        // circles touching exactly
        pending_pairs.push_back('{make_obj(SHAPE_DISC, 0, 0, 3, 0, 1),
                                  make_obj(SHAPE_DISC, 5, 0, 2, 0, 1)});
        // circle meets a box corner at distance equal to the radius
        pending_pairs.push_back('{make_obj(SHAPE_DISC, 7, 6, 5, 0, 1),
                                  make_obj(SHAPE_TOP_LEFT, 10, 10, 5, 5, 1)});
        // boxes sharing one edge
        pending_pairs.push_back('{make_obj(SHAPE_TOP_LEFT, 0, 0, 10, 10, 1),
                                  make_obj(SHAPE_TOP_LEFT, 10, 0, 5, 5, 1)});
        // bottom-left and centre boxes sharing one corner
        pending_pairs.push_back('{make_obj(SHAPE_BOT_LEFT, 0, 0, 4, 4, 1),
                                  make_obj(SHAPE_CENTRE, 6, 2, 4, 4, 1)});
        // odd centre size loses a pixel, so the point just misses
        pending_pairs.push_back('{make_obj(SHAPE_CENTRE, 0, 0, 3, 3, 1),
                                  make_obj(SHAPE_TOP_LEFT, 2, 0, 0, 0, 1)});
        // widest centre box against a circle given second
        pending_pairs.push_back('{make_obj(SHAPE_CENTRE, 0, 0, 255, 255, 1),
                                  make_obj(SHAPE_DISC, 130, 0, 3, 0, 1)});
        // disabled objects on fully overlapping shapes
        pending_pairs.push_back('{make_obj(SHAPE_DISC, 0, 0, 10, 0, 0),
                                  make_obj(SHAPE_DISC, 0, 0, 10, 0, 1)});
        pending_pairs.push_back('{make_obj(SHAPE_TOP_LEFT, 0, 0, 10, 10, 1),
                                  make_obj(SHAPE_TOP_LEFT, 0, 0, 10, 10, 0)});
        // coordinate and size extremes
        pending_pairs.push_back('{make_obj(SHAPE_TOP_LEFT, COORD_MIN, COORD_MIN, 255, 255, 1),
                                  make_obj(SHAPE_DISC, COORD_MIN, COORD_MIN, 0, 0, 1)});
        pending_pairs.push_back('{make_obj(SHAPE_DISC, COORD_MAX, COORD_MAX, 255, 255, 1),
                                  make_obj(SHAPE_DISC, COORD_MAX - 510, COORD_MAX, 255,
                                           0, 1)});
        // zero-width line meeting a point
        pending_pairs.push_back('{make_obj(SHAPE_TOP_LEFT, 0, 0, 0, 50, 1),
                                  make_obj(SHAPE_BOT_LEFT, 0, 50, 0, 0, 1)});
        // every shape combination
        for (sa = 0; sa < 4; sa++)
            for (sb = 0; sb < 4; sb++)
                pending_pairs.push_back('{make_obj(SHAPE_BITS'(sa), 100, -100, 20, 12, 1),
                                          make_obj(SHAPE_BITS'(sb), 118, -90, 9, 5, 1)});
        repeat (RANDOM_PAIRS)
            pending_pairs.push_back(random_pair());
        total_pairs = pending_pairs.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pairs_accepted < total_pairs || hit_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
